FILE: hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap page allocator.
// No dependencies; every other file of the block but bpa_bitmap imports this package.
package bpa_pkg;

    // Width and ceiling of the free-page count.
    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

    // Command codes carried by an input item.
    typedef enum logic [2:0] {
        CMD_ALLOC = 3'd0,
        CMD_ALIGN = 3'd1,
        CMD_FREE  = 3'd2,
        CMD_MUSED = 3'd3,
        CMD_MFREE = 3'd4
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_RUN  = 2'd1,
        ST_INVALID = 2'd2,
        ST_DOUBLE  = 2'd3
    } t_status;

endpackage

FILE: hw/rtl/bpa_cmd_if.sv
`timescale 1ns / 1ps
// Command and result channel interfaces of the bitmap page allocator.
// Depends on bpa_pkg for the count width.
interface bpa_cmd_if import bpa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic [15:0]       base_page;
    logic [CNT_W-1:0]  page_count;
    logic [CNT_W-1:0]  page_align;

    modport source (output valid, command, base_page, page_count, page_align,
                    input ready);
    modport sink (input valid, command, base_page, page_count, page_align,
                  output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [15:0]       found_page;
    logic [CNT_W-1:0]  free_count;

    modport source (output valid, status, found_page, free_count, input ready);
    modport sink (input valid, status, found_page, free_count, output ready);
endinterface

FILE: hw/rtl/bpa_bitmap.sv
`timescale 1ns / 1ps
// Occupancy bitmap memory: one port for reads with registered data, one for writes.
// After reset a sweep sets every word to all ones; no dependencies.
module bpa_bitmap #(
    parameter int NUM_WORDS = 1024,
    parameter int WORD_BITS = 64,
    parameter int WIW       = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [WIW-1:0]       i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [WIW-1:0]       i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data,
    output logic                 o_ready
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [WIW-1:0]       r_clr_idx;
    logic                 r_clr_busy;

    // Clearing sweep, one word per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            if (r_clr_idx == WIW'(NUM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Single write port, shared by the sweep and the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '1;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr_busy;

endmodule

FILE: hw/rtl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// Bitmap page allocator: channels i_cmd (command items) and o_rsp (one result
// item per command), plus an APB register port holding the page total at address 0.
// A sequencer walks the occupancy bitmap one page per cycle through one cached
// word, pausing at each word boundary to write the word back in S_WB when it
// is dirty and to load the next one from memory through S_LOAD and S_GRAB.
// Allocate scans from page 0 for the first fitting run, then seeks back to the
// run start and marks it used. Free and mark seek to the start page, then set
// or clear each page of the range. Invalid or empty commands go from S_IDLE
// straight to S_RESP. The page walk sets the rate; one item is in work at a time.
// After reset the bitmap memory is swept to all used, one word per cycle
// (NUM_WORDS words, 1024 by default); no item is accepted until it ends.
// Configuration writes are taken at any time. A result waits in an output
// register while the receiver stalls; the next item is still accepted, and
// its result is held back until the register is free.
module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int MAX_PAGES = 65536,
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpa_cmd_if.sink     i_cmd,
    bpa_rsp_if.source   o_rsp,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int PGW       = $clog2(MAX_PAGES) + 1;
    localparam int AW        = (PGW > 18) ? PGW : 18;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SEEK, S_LOAD, S_GRAB, S_WORK, S_WB, S_RESP
    } t_state;

    typedef enum logic [2:0] {
        M_FIND, M_SET, M_FREE, M_MUSED, M_MFREE
    } t_mode;

    typedef enum logic [1:0] {
        A_LOAD, A_SEEK, A_DONE
    } t_after;

    t_state               r_state;
    t_mode                r_mode;
    t_after               r_after;
    t_status              r_stat;
    t_status              r_o_stat;
    logic [AW-1:0]        r_p, r_end, r_n, r_align, r_run, r_smod, r_rem, r_span;
    logic [WIW-1:0]       r_widx;
    logic [BW-1:0]        r_bit;
    logic [WORD_BITS-1:0] r_word;
    logic                 r_dirty;
    logic [15:0]          r_found, r_o_found;
    logic [CNT_W-1:0]     r_fcount, r_o_cnt, r_total;
    logic                 r_vld;

    logic [WORD_BITS-1:0] mem_rd;
    logic                 mem_ready;
    logic                 mem_wr;

    logic [AW-1:0]        n_et, n_st, n_cnt, n_al, n_sum, n_lim;
    logic                 n_b, n_hit, n_last, n_wend, n_v;
    logic [AW-1:0]        n_run, n_pn, n_s;
    logic [CNT_W-1:0]     n_fc;

    // Saturating count helpers.
    function automatic logic [CNT_W-1:0] cnt_up(logic [CNT_W-1:0] c, logic [AW-1:0] n);
        logic [AW:0] s;
        s = (AW+1)'(c) + (AW+1)'(n);
        return (s > (AW+1)'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dn(logic [CNT_W-1:0] c, logic [AW-1:0] n);
        logic [AW-1:0] cw;
        cw = AW'(c);
        return (cw > n) ? CNT_W'(cw - n) : '0;
    endfunction

    // Request decode at acceptance.
    always_comb begin
        n_et  = (AW'(r_total) > AW'(MAX_PAGES)) ? AW'(MAX_PAGES) : AW'(r_total);
        n_st  = AW'(i_cmd.base_page);
        n_cnt = AW'(i_cmd.page_count);
        n_al  = (i_cmd.command == CMD_ALLOC) ? AW'(1) : AW'(i_cmd.page_align);
        n_sum = n_st + n_cnt;
        n_lim = (n_sum > n_et) ? n_et : n_sum;
    end

    // Per-page step on the cached word.
    always_comb begin
        n_b    = r_word[r_bit];
        n_run  = n_b ? '0 : r_run + 1'b1;
        n_hit  = !n_b && (n_run >= r_n) && (r_smod == '0);
        n_pn   = r_p + 1'b1;
        n_s    = r_p + 1'b1 - r_n;
        n_last = (n_pn == r_end);
        n_wend = (r_bit == BW'(WORD_BITS - 1));
        n_v    = (r_mode == M_SET) || (r_mode == M_MUSED);
        case (r_mode)
            M_FREE:  n_fc = n_last ? cnt_up(r_fcount, r_span) : r_fcount;
            M_SET:   n_fc = n_last ? cnt_dn(r_fcount, r_n) : r_fcount;
            M_MUSED: n_fc = !n_b ? cnt_dn(r_fcount, AW'(1)) : r_fcount;
            M_MFREE: n_fc = n_b ? cnt_up(r_fcount, AW'(1)) : r_fcount;
            default: n_fc = r_fcount;
        endcase
    end

    // Sequencer, count, configuration register and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_vld    <= 1'b0;
            r_fcount <= '0;
            r_total  <= '0;
            r_dirty  <= 1'b0;
        end else begin
            if (i_psel && i_penable && i_pwrite && !i_paddr[2]) begin
                r_total <= i_pwdata[CNT_W-1:0];
            end
            if (r_vld && o_rsp.ready && (r_state != S_RESP)) begin
                r_vld <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (mem_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_stat  <= ST_OK;
                        r_found <= '0;
                        r_run   <= '0;
                        r_smod  <= '0;
                        r_widx  <= '0;
                        r_rem   <= n_st;
                        r_p     <= n_st;
                        r_end   <= n_lim;
                        r_span  <= n_lim - n_st;
                        r_dirty <= 1'b0;
                        r_state <= S_RESP;
                        case (i_cmd.command)
                            CMD_ALLOC, CMD_ALIGN: begin
                                if (n_cnt == '0 || n_al == '0) begin
                                    r_stat <= ST_INVALID;
                                end else if (n_cnt > n_et) begin
                                    r_stat <= ST_NO_RUN;
                                end else begin
                                    r_mode  <= M_FIND;
                                    r_n     <= n_cnt;
                                    r_align <= n_al;
                                    r_p     <= '0;
                                    r_end   <= n_et;
                                    r_bit   <= '0;
                                    r_state <= S_LOAD;
                                end
                            end
                            CMD_FREE: begin
                                if (n_cnt != '0) begin
                                    if (n_st >= n_et) begin
                                        r_stat <= ST_INVALID;
                                    end else begin
                                        r_mode  <= M_FREE;
                                        r_state <= S_SEEK;
                                    end
                                end
                            end
                            CMD_MUSED, CMD_MFREE: begin
                                if (n_cnt != '0 && n_st < n_et) begin
                                    r_mode  <= (i_cmd.command == CMD_MUSED) ? M_MUSED : M_MFREE;
                                    r_state <= S_SEEK;
                                end
                            end
                            default: begin
                                r_stat <= ST_INVALID;
                            end
                        endcase
                    end
                end
                S_SEEK: begin
                    if (r_rem >= AW'(WORD_BITS)) begin
                        r_rem  <= r_rem - AW'(WORD_BITS);
                        r_widx <= r_widx + 1'b1;
                    end else begin
                        r_bit   <= r_rem[BW-1:0];
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_GRAB;
                end
                S_GRAB: begin
                    r_word  <= mem_rd;
                    r_dirty <= 1'b0;
                    r_state <= S_WORK;
                end
                S_WORK: begin
                    r_p <= n_pn;
                    if (r_mode == M_FIND) begin
                        r_run <= n_run;
                        if (r_p >= r_n - 1'b1) begin
                            r_smod <= (r_smod == r_align - 1'b1) ? '0 : r_smod + 1'b1;
                        end
                    end else begin
                        r_word[r_bit] <= n_v;
                        r_dirty       <= 1'b1;
                        r_fcount      <= n_fc;
                        if (r_mode == M_FREE && !n_b) begin
                            r_stat <= ST_DOUBLE;
                        end
                    end
                    if (r_mode == M_FIND && n_hit) begin
                        // Run found: go back to its start and mark it used.
                        r_found <= n_s[15:0];
                        r_p     <= n_s;
                        r_rem   <= n_s;
                        r_end   <= n_s + r_n;
                        r_mode  <= M_SET;
                        r_after <= A_SEEK;
                        r_state <= S_WB;
                    end else if (n_last) begin
                        if (r_mode == M_FIND) begin
                            r_stat <= ST_NO_RUN;
                        end
                        r_after <= A_DONE;
                        r_state <= S_WB;
                    end else if (n_wend) begin
                        r_after <= A_LOAD;
                        r_state <= S_WB;
                    end else begin
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_WB: begin
                    r_dirty <= 1'b0;
                    case (r_after)
                        A_LOAD: begin
                            r_widx  <= r_widx + 1'b1;
                            r_bit   <= '0;
                            r_state <= S_LOAD;
                        end
                        A_SEEK: begin
                            r_widx  <= '0;
                            r_state <= S_SEEK;
                        end
                        default: begin
                            r_state <= S_RESP;
                        end
                    endcase
                end
                S_RESP: begin
                    if (!r_vld || o_rsp.ready) begin
                        r_vld     <= 1'b1;
                        r_o_stat  <= r_stat;
                        r_o_found <= r_found;
                        r_o_cnt   <= r_fcount;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign mem_wr = (r_state == S_WB) && r_dirty;

    bpa_bitmap #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS),
        .WIW       (WIW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_widx),
        .o_rd_data (mem_rd),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_widx),
        .i_wr_data (r_word),
        .o_ready   (mem_ready)
    );

    // Channel and register port outputs.
    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_vld;
    assign o_rsp.status     = r_o_stat;
    assign o_rsp.found_page = r_o_found;
    assign o_rsp.free_count = r_o_cnt;
    assign o_prdata         = i_paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, r_total};
    assign o_pready         = 1'b1;

`ifndef SYNTHESIS
    a_found_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status != ST_OK) |-> o_rsp.found_page == 16'd0)
        else $error("found page set on a failed result");
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr |-> mem_ready)
        else $error("bitmap written during the clearing sweep");
    a_find_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WORK) && (r_mode == M_FIND) |-> !r_dirty)
        else $error("search pass modified the cached word");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap page allocator: directed and random
// command items, an internal occupancy model, and APB writes of the page total.
// Depends on bpa_pkg, the bpa_cmd_if/bpa_rsp_if interfaces and the block's RTL.
module testbench;
    import bpa_pkg::*;

    localparam int PAGES_MAX = 65536;
    localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
    localparam logic [2:0] REG_PAGE_TOTAL = 3'd0;

    typedef struct packed {
        logic [2:0]       command;
        logic [15:0]      base_page;
        logic [CNT_W-1:0] page_count;
        logic [CNT_W-1:0] page_align;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      found_page;
        logic [CNT_W-1:0] free_count;
    } t_rsp_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [2:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    bpa_cmd_if cmd_ch ();
    bpa_rsp_if rsp_ch ();

    bitmap_page_allocator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .o_rsp     (rsp_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #5 i_clk = ~i_clk;

    // Occupancy model: one bit per page, 1 means used.
    bit               page_busy [PAGES_MAX];
    logic [CNT_W-1:0] model_free_count;
    logic [CNT_W-1:0] model_total;

    t_cmd_item pending_cmds[$];
    t_rsp_item expected_rsps[$];
    int        error_count = 0;
    int        cmds_taken = 0;
    int        cmds_queued = 0;
    bit        cmd_taken = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    bit        random_phase = 1'b0;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.base_page = '0;
        cmd_ch.page_count = '0;
        cmd_ch.page_align = '0;
        rsp_ch.ready = 1'b0;
        for (int p = 0; p < PAGES_MAX; p++) page_busy[p] = 1'b1;
        model_free_count = '0;
        model_total = '0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic int effective_total();
        return (model_total > PAGES_MAX) ? PAGES_MAX : int'(model_total);
    endfunction

    function automatic void count_lower(input int n);
        model_free_count = (int'(model_free_count) > n) ?
                           CNT_W'(int'(model_free_count) - n) : '0;
    endfunction

    function automatic void count_raise(input int n);
        int s;
        s = int'(model_free_count) + n;
        model_free_count = (s > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(s);
    endfunction

    // Lowest aligned start of a run of n free pages, or -1.
    function automatic int first_fit(input int n, input int align);
        int run;
        int s;
        run = 0;
        for (int p = 0; p < effective_total(); p++) begin
            if (page_busy[p]) begin
                run = 0;
            end else begin
                run++;
                if (run >= n) begin
                    s = p + 1 - n;
                    if (s % align == 0) return s;
                end
            end
        end
        return -1;
    endfunction

    // Applies one command to the model and returns the result it should give.
    function automatic t_rsp_item allocator_outcome(input t_cmd_item it);
        t_rsp_item r;
        int total, start, count, align, stop, s;
        total = effective_total();
        start = it.base_page;
        count = it.page_count;
        align = (it.command == CMD_ALLOC) ? 1 : int'(it.page_align);
        stop = (start + count > total) ? total : start + count;
        r.status = ST_OK;
        r.found_page = '0;
        if (it.command == CMD_ALLOC || it.command == CMD_ALIGN) begin
            if (count == 0 || align == 0) begin
                r.status = ST_INVALID;
            end else begin
                s = (count > total) ? -1 : first_fit(count, align);
                if (s < 0) begin
                    r.status = ST_NO_RUN;
                end else begin
                    for (int p = s; p < s + count; p++) page_busy[p] = 1'b1;
                    count_lower(count);
                    r.found_page = 16'(s);
                end
            end
        end else if (it.command == CMD_FREE) begin
            if (count != 0) begin
                if (start >= total) begin
                    r.status = ST_INVALID;
                end else begin
                    for (int p = start; p < stop; p++) begin
                        if (!page_busy[p]) r.status = ST_DOUBLE;
                        page_busy[p] = 1'b0;
                    end
                    count_raise(stop - start);
                end
            end
        end else if (it.command == CMD_MUSED || it.command == CMD_MFREE) begin
            for (int p = start; p < stop; p++) begin
                if (page_busy[p] != (it.command == CMD_MUSED)) begin
                    page_busy[p] = (it.command == CMD_MUSED);
                    if (it.command == CMD_MUSED) count_lower(1);
                    else count_raise(1);
                end
            end
        end else begin
            r.status = ST_INVALID;
        end
        r.free_count = model_free_count;
        return r;
    endfunction

    // Idle lengths: mostly short, a few long, with stretches of none.
    function automatic int idle_length();
        int r;
        if ((cmds_taken / 50) % 4 == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Accepted commands and results are taken at the rising edge.
    always @(posedge i_clk) begin
        t_rsp_item want;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            cmd_taken = 1'b1;
            cmds_taken++;
            expected_rsps.push_back(allocator_outcome({cmd_ch.command, cmd_ch.base_page,
                                                       cmd_ch.page_count,
                                                       cmd_ch.page_align}));
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result, status", rsp_ch.status, -1);
            end else begin
                want = expected_rsps.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.found_page !== want.found_page)
                    report_mismatch("found_page", rsp_ch.found_page, want.found_page);
                if (rsp_ch.free_count !== want.free_count)
                    report_mismatch("free_count", rsp_ch.free_count, want.free_count);
            end
        end
    end

    // Command driver: holds an item until taken, then idles or sends the next.
    always @(negedge i_clk) begin
        t_cmd_item it;
        if (!(cmd_ch.valid && !cmd_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                cmd_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                it = pending_cmds.pop_front();
                cmd_ch.command <= it.command;
                cmd_ch.base_page <= it.base_page;
                cmd_ch.page_count <= it.page_count;
                cmd_ch.page_align <= it.page_align;
                cmd_ch.valid <= 1'b1;
                send_gap = idle_length();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
        cmd_taken = 1'b0;
    end

    // Result receiver, with one long hold-off during the random part.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (random_phase && !hold_done && cmds_taken > 60) begin
            hold_done = 1'b1;
            hold_left = 3000;
            rsp_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            recv_gap = idle_length();
        end
    end

    task automatic write_total(input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_psel = 1'b1;
        i_pwrite = 1'b1;
        i_paddr = REG_PAGE_TOTAL;
        i_pwdata = 32'(value);
        @(negedge i_clk);
        i_penable = 1'b1;
        @(negedge i_clk);
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        model_total = value;
    endtask

    task automatic queue_cmd(input logic [2:0] c, input int s, input int n, input int a);
        pending_cmds.push_back({c, 16'(s), 17'(n), 17'(a)});
        cmds_queued++;
    endtask

    // Waits until every queued item has been taken and answered.
    task automatic wait_drained();
        while (cmds_taken != cmds_queued || expected_rsps.size() != 0)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // Random command: mostly plausible ranges within the total, some noise.
    task automatic queue_random_cmd(input int total);
        int r, c, n, a;
        int aligns[9] = '{1, 2, 4, 8, 16, 32, 64, 3, 0};
        r = $urandom_range(0, 99);
        if (r < 8) begin
            pending_cmds.push_back({3'($urandom), 16'($urandom), 17'($urandom),
                                    17'($urandom)});
            cmds_queued++;
        end else begin
            r = $urandom_range(0, 99);
            c = (r < 30) ? CMD_ALLOC : (r < 50) ? CMD_ALIGN : (r < 75) ? CMD_FREE :
                (r < 85) ? CMD_MUSED : CMD_MFREE;
            r = $urandom_range(0, 99);
            n = (r < 80) ? $urandom_range(1, 12) : (r < 95) ? $urandom_range(0, total + 2) : 0;
            a = aligns[$urandom_range(0, 8)];
            queue_cmd(3'(c), $urandom_range(0, total + 3), n, a);
        end
    endtask

    initial begin
        int total;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Nothing managed: every command sees an empty page space.
        write_total('0);
        queue_cmd(CMD_ALLOC, 0, 1, 0);
        queue_cmd(CMD_FREE, 0, 1, 0);
        queue_cmd(CMD_MFREE, 0, 4, 0);
        wait_drained();

        // One word of pages: each command and its corner cases.
        write_total(17'd64);
        queue_cmd(CMD_ALLOC, 0, 0, 0);
        queue_cmd(CMD_MFREE, 0, 64, 0);
        queue_cmd(CMD_ALLOC, 0, 1, 0);
        queue_cmd(CMD_ALIGN, 0, 4, 0);
        queue_cmd(CMD_ALIGN, 0, 4, 8);
        queue_cmd(CMD_FREE, 0, 2, 0);
        queue_cmd(CMD_FREE, 64, 1, 0);
        queue_cmd(CMD_FREE, 0, 0, 0);
        queue_cmd(CMD_MUSED, 60, 10, 0);
        queue_cmd(CMD_MUSED, 70, 3, 0);
        queue_cmd(CMD_ALLOC, 0, 65, 0);
        queue_cmd(CMD_ALLOC, 0, 60, 0);
        queue_cmd(CMD_MFREE, 62, 40, 0);
        queue_cmd(CMD_ALIGN, 0, 1, 65536);
        queue_cmd(CMD_UNKNOWN_LO, 0, 1, 1);
        queue_cmd(CMD_UNKNOWN_HI, 65535, 131071, 131071);
        wait_drained();

        // Total above the maximum: whole page space, count saturating high.
        write_total(17'h1FFFF);
        queue_cmd(CMD_MFREE, 0, 65536, 0);
        queue_cmd(CMD_FREE, 0, 65536, 0);
        queue_cmd(CMD_ALLOC, 0, 65536, 0);
        queue_cmd(CMD_ALLOC, 0, 1, 0);
        queue_cmd(CMD_FREE, 65535, 1, 0);
        queue_cmd(CMD_ALLOC, 0, 1, 0);
        wait_drained();

        write_total(17'd65536);
        queue_cmd(CMD_FREE, 65535, 2, 0);
        wait_drained();

        // Random part over several small page totals.
        random_phase = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            total = (ph == 0) ? 1 : (ph == 1) ? 63 : (ph == 2) ? 65 :
                    (ph == 3) ? 300 : $urandom_range(2, 300);
            write_total(17'(total));
            queue_cmd(CMD_MFREE, 0, total, 0);
            for (int k = 0; k < 90; k++) queue_random_cmd(total);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_cmd_if.sv
hw/rtl/bpa_bitmap.sv
hw/rtl/bitmap_page_allocator.sv
tb/sv/testbench.sv
